>>> hdl/adts_frame_scanner_unit_defines.svh
// ============================================================================
// ADTS frame scanner assertion macros
// Concurrent assertion shorthands, clocked on clk and disabled in reset.
// ============================================================================
`ifndef ADTS_FRAME_SCANNER_UNIT_DEFINES_SVH
`define ADTS_FRAME_SCANNER_UNIT_DEFINES_SVH

// same-cycle implication
`define ADTS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ADTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/adts_fs_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// ADTS frame scanner package
// Shared constants, types and the sampling rate table.
// ============================================================================
package adts_fs_pkg;

  localparam int WINDOW_BYTES_DEF = 4608;
  localparam int ITEM_Q_DEPTH_DEF = 4;
  localparam int RESULT_Q_DEPTH   = 2;

  localparam int LEN_W       = 13;
  localparam int FRAME_CNT_W = 24;
  localparam int TOTAL_W     = 32;
  localparam int RATE_IDX_W  = 4;
  localparam int RATE_HZ_W   = 17;
  localparam int CAUSE_W     = 2;

  localparam logic [7:0] SYNC_BYTE  = 8'hFF;
  localparam logic [7:0] SYNC2_MASK = 8'hF6;
  localparam logic [7:0] SYNC2_VAL  = 8'hF0;

  localparam int MIN_FRAME_LEN    = 7;
  localparam int HEADER_BYTES     = 8;
  localparam int SEARCH_LOST_BYTES = 8;

  typedef enum logic [1:0] {
    PH_SEARCH,
    PH_HEADER,
    PH_BODY,
    PH_STOP
  } phase_t;

  typedef enum logic [CAUSE_W-1:0] {
    CAUSE_END       = 2'd0,
    CAUSE_LOST_SYNC = 2'd1,
    CAUSE_SHORT     = 2'd2,
    CAUSE_LONG      = 2'd3
  } cause_t;

  typedef enum logic [2:0] {
    HP_SYNC_HI,
    HP_SYNC_LO,
    HP_RATE,
    HP_LEN_HI,
    HP_LEN_MID,
    HP_LEN_LO,
    HP_SPARE,
    HP_JUDGE
  } hdr_pos_t;

  typedef struct packed {
    logic [7:0] data;
    logic       byte_ok;
    logic       eos;
    logic       is_ff;
    logic       is_sync2;
  } item_t;

  typedef struct packed {
    logic [FRAME_CNT_W-1:0] frame_count;
    logic [TOTAL_W-1:0]     total_frame_bytes;
    logic [RATE_IDX_W-1:0]  rate_index;
    logic [RATE_HZ_W-1:0]   sample_rate;
    logic                   sync_found;
    logic [CAUSE_W-1:0]     stop_cause;
  } result_t;

  function automatic logic [RATE_HZ_W-1:0] rate_hz(input logic [RATE_IDX_W-1:0] idx);
    logic [RATE_HZ_W-1:0] hz;
    unique case (idx)
      4'd0:    hz = 17'd96000;
      4'd1:    hz = 17'd88200;
      4'd2:    hz = 17'd64000;
      4'd3:    hz = 17'd48000;
      4'd4:    hz = 17'd44100;
      4'd5:    hz = 17'd32000;
      4'd6:    hz = 17'd24000;
      4'd7:    hz = 17'd22050;
      4'd8:    hz = 17'd16000;
      4'd9:    hz = 17'd12000;
      4'd10:   hz = 17'd11025;
      4'd11:   hz = 17'd8000;
      4'd12:   hz = 17'd7350;
      default: hz = '0;
    endcase
    return hz;
  endfunction

endpackage

>>> hdl/adts_fs_queue.sv
`timescale 1ns / 1ps
// ============================================================================
// ADTS frame scanner queue
// Small show-ahead FIFO of flops used between the scanner stages.
// ============================================================================
module adts_fs_queue #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             wr_en;
  logic             rd_en;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign wr_en   = push & ~full;
  assign rd_en   = pop & ~empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({wr_en, rd_en})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

>>> hdl/adts_fs_front.sv
`timescale 1ns / 1ps
// ============================================================================
// ADTS frame scanner front end
// Takes input transactions, drops idle ones and pre-decodes sync bytes.
// ============================================================================
module adts_fs_front (
  input  logic                in_push,
  input  logic [7:0]          in_data_byte,
  input  logic                in_byte_valid,
  input  logic                in_end_of_stream,
  output logic                in_full,
  input  logic                q_full,
  output logic                q_push,
  output adts_fs_pkg::item_t  q_item
);

  import adts_fs_pkg::*;

  assign in_full = q_full;
  assign q_push  = in_push & ~q_full & (in_byte_valid | in_end_of_stream);

  always_comb begin
    q_item.data     = in_data_byte;
    q_item.byte_ok  = in_byte_valid;
    q_item.eos      = in_end_of_stream;
    q_item.is_ff    = (in_data_byte == SYNC_BYTE);
    q_item.is_sync2 = ((in_data_byte & SYNC2_MASK) == SYNC2_VAL);
  end

endmodule

>>> hdl/adts_fs_back.sv
`timescale 1ns / 1ps
// ============================================================================
// ADTS frame scanner back end
// Sync search, header walk, frame counting and summary generation.
// ============================================================================
module adts_fs_back #(
  parameter int WINDOW_BYTES = adts_fs_pkg::WINDOW_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  item_empty,
  input  adts_fs_pkg::item_t    item,
  output logic                  item_pop,
  input  logic                  res_full,
  output logic                  res_push,
  output adts_fs_pkg::result_t  res
);

  import adts_fs_pkg::*;

  localparam int SCNT_W = $clog2(WINDOW_BYTES);
  localparam logic [SCNT_W-1:0] SCNT_LAST = SCNT_W'(WINDOW_BYTES - 1);
  localparam logic [LEN_W:0]    WIN_LEN   = (LEN_W + 1)'(WINDOW_BYTES);

  phase_t                 phase_r, phase_s, phase_nxt;
  hdr_pos_t               hdr_pos_r, hdr_pos_nxt;
  cause_t                 stop_r, stop_nxt;
  logic [SCNT_W-1:0]      search_r, search_nxt;
  logic                   prev_ff_r, prev_ff_nxt;
  logic                   sync_seen_r, sync_seen_nxt;
  logic                   rate_taken_r, rate_taken_nxt;
  logic [RATE_IDX_W-1:0]  first_rate_r, first_rate_nxt;
  logic [FRAME_CNT_W-1:0] frames_r, frames_nxt;
  logic [TOTAL_W-1:0]     total_r, total_nxt;

  logic                   sync_ok_r, sync_ok_nxt;
  logic [RATE_IDX_W-1:0]  rate_raw_r, rate_raw_nxt;
  logic [1:0]             len_hi_r, len_hi_nxt;
  logic [7:0]             len_mid_r, len_mid_nxt;
  logic [LEN_W-1:0]       left_r, left_nxt;

  logic                   byte_go;
  logic                   end_go;
  logic                   sync_hit;
  logic                   win_end;
  logic                   judge;
  logic                   len_short;
  logic                   len_big;
  logic                   len_seven;
  logic                   len_eight;
  logic                   body_last;
  logic [FRAME_CNT_W-1:0] frames_inc;
  logic [TOTAL_W:0]       total_sum;
  logic [TOTAL_W-1:0]     total_sat;

  assign item_pop = ~item_empty & (~item.eos | ~res_full);
  assign byte_go  = item_pop & item.byte_ok;
  assign end_go   = item_pop & item.eos;
  assign res_push = end_go;

  always_comb begin
    sync_hit   = (search_r != '0) & prev_ff_r & item.is_sync2;
    win_end    = (search_r == SCNT_LAST);
    judge      = (hdr_pos_r == HP_JUDGE);
    len_short  = (left_r < LEN_W'(MIN_FRAME_LEN));
    len_big    = ({1'b0, left_r} > WIN_LEN);
    len_seven  = (left_r == LEN_W'(MIN_FRAME_LEN));
    len_eight  = (left_r == LEN_W'(HEADER_BYTES));
    body_last  = (left_r == LEN_W'(1));
    frames_inc = (frames_r == '1) ? frames_r : frames_r + 1'b1;
    total_sum  = {1'b0, total_r} + (TOTAL_W + 1)'(left_r);
    total_sat  = total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];
  end

  // next state
  always_comb begin
    phase_s = phase_r;
    if (byte_go) begin
      unique case (phase_r)
        PH_SEARCH: begin
          if (sync_hit) begin
            phase_s = PH_HEADER;
          end else if (win_end) begin
            phase_s = PH_STOP;
          end
        end
        PH_HEADER: begin
          if (judge) begin
            if (!sync_ok_r || len_short || len_big) begin
              phase_s = PH_STOP;
            end else if (!len_seven && !len_eight) begin
              phase_s = PH_BODY;
            end
          end
        end
        PH_BODY: begin
          if (body_last) begin
            phase_s = PH_HEADER;
          end
        end
        PH_STOP: phase_s = PH_STOP;
        default: phase_s = phase_r;
      endcase
    end
    phase_nxt = end_go ? PH_SEARCH : phase_s;
  end

  // datapath and summary
  always_comb begin
    hdr_pos_nxt    = hdr_pos_r;
    stop_nxt       = stop_r;
    search_nxt     = search_r;
    prev_ff_nxt    = prev_ff_r;
    sync_seen_nxt  = sync_seen_r;
    rate_taken_nxt = rate_taken_r;
    first_rate_nxt = first_rate_r;
    frames_nxt     = frames_r;
    total_nxt      = total_r;
    sync_ok_nxt    = sync_ok_r;
    rate_raw_nxt   = rate_raw_r;
    len_hi_nxt     = len_hi_r;
    len_mid_nxt    = len_mid_r;
    left_nxt       = left_r;

    if (byte_go) begin
      prev_ff_nxt = item.is_ff;
      unique case (phase_r)
        PH_SEARCH: begin
          if (sync_hit) begin
            sync_seen_nxt = 1'b1;
            sync_ok_nxt   = 1'b1;
            hdr_pos_nxt   = HP_RATE;
          end else if (win_end) begin
            stop_nxt = CAUSE_LOST_SYNC;
          end else begin
            search_nxt = search_r + 1'b1;
          end
        end
        PH_HEADER: begin
          hdr_pos_nxt = hdr_pos_t'(hdr_pos_r + 3'd1);
          unique case (hdr_pos_r)
            HP_SYNC_HI: sync_ok_nxt = item.is_ff;
            HP_SYNC_LO: sync_ok_nxt = sync_ok_r & item.is_sync2;
            HP_RATE:    rate_raw_nxt = item.data[5:2];
            HP_LEN_HI:  len_hi_nxt = item.data[1:0];
            HP_LEN_MID: len_mid_nxt = item.data;
            HP_LEN_LO:  left_nxt = {len_hi_r, len_mid_r, item.data[7:5]};
            HP_SPARE:   hdr_pos_nxt = HP_JUDGE;
            HP_JUDGE: begin
              hdr_pos_nxt = HP_JUDGE;
              if (!sync_ok_r) begin
                stop_nxt = CAUSE_LOST_SYNC;
              end else begin
                if (!rate_taken_r) begin
                  first_rate_nxt = rate_raw_r;
                  rate_taken_nxt = 1'b1;
                end
                if (len_short) begin
                  stop_nxt = CAUSE_SHORT;
                end else begin
                  total_nxt = total_sat;
                  if (len_big) begin
                    stop_nxt = CAUSE_LONG;
                  end else if (len_seven) begin
                    // this byte opens the next header
                    frames_nxt  = frames_inc;
                    sync_ok_nxt = item.is_ff;
                    hdr_pos_nxt = HP_SYNC_LO;
                  end else begin
                    hdr_pos_nxt = HP_SYNC_HI;
                    left_nxt    = left_r - LEN_W'(HEADER_BYTES);
                    if (len_eight) begin
                      frames_nxt = frames_inc;
                    end
                  end
                end
              end
            end
            default: hdr_pos_nxt = hdr_pos_r;
          endcase
        end
        PH_BODY: begin
          left_nxt = left_r - 1'b1;
          if (body_last) begin
            frames_nxt  = frames_inc;
            hdr_pos_nxt = HP_SYNC_HI;
          end
        end
        PH_STOP: prev_ff_nxt = item.is_ff;
        default: prev_ff_nxt = item.is_ff;
      endcase
    end

    res.frame_count       = frames_nxt;
    res.total_frame_bytes = total_nxt;
    res.rate_index        = rate_taken_nxt ? first_rate_nxt : '0;
    res.sample_rate       = rate_taken_nxt ? rate_hz(first_rate_nxt) : '0;
    res.sync_found        = sync_seen_nxt;
    if (phase_s == PH_STOP) begin
      res.stop_cause = stop_nxt;
    end else if (phase_s == PH_SEARCH && search_nxt >= SCNT_W'(SEARCH_LOST_BYTES)) begin
      res.stop_cause = CAUSE_LOST_SYNC;
    end else begin
      res.stop_cause = CAUSE_END;
    end

    if (end_go) begin
      hdr_pos_nxt    = HP_SYNC_HI;
      stop_nxt       = CAUSE_END;
      search_nxt     = '0;
      prev_ff_nxt    = 1'b0;
      sync_seen_nxt  = 1'b0;
      rate_taken_nxt = 1'b0;
      first_rate_nxt = '0;
      frames_nxt     = '0;
      total_nxt      = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_SEARCH;
      hdr_pos_r    <= HP_SYNC_HI;
      stop_r       <= CAUSE_END;
      search_r     <= '0;
      prev_ff_r    <= 1'b0;
      sync_seen_r  <= 1'b0;
      rate_taken_r <= 1'b0;
      first_rate_r <= '0;
      frames_r     <= '0;
      total_r      <= '0;
    end else begin
      phase_r      <= phase_nxt;
      hdr_pos_r    <= hdr_pos_nxt;
      stop_r       <= stop_nxt;
      search_r     <= search_nxt;
      prev_ff_r    <= prev_ff_nxt;
      sync_seen_r  <= sync_seen_nxt;
      rate_taken_r <= rate_taken_nxt;
      first_rate_r <= first_rate_nxt;
      frames_r     <= frames_nxt;
      total_r      <= total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sync_ok_r  <= sync_ok_nxt;
    rate_raw_r <= rate_raw_nxt;
    len_hi_r   <= len_hi_nxt;
    len_mid_r  <= len_mid_nxt;
    left_r     <= left_nxt;
  end

endmodule

>>> hdl/adts_frame_scanner_unit.sv
`timescale 1ns / 1ps
// ============================================================================
// ADTS frame scanner unit
// Scans an ADTS byte stream and reports frame count, byte total, sampling
// rate and stop cause once per stream.
// ============================================================================
// One byte transaction is taken per clock while in_full is low. Accepted
// transactions enter an item queue (ITEM_QUEUE_DEPTH deep); the scan engine
// drains it at one item per cycle, stalling only while an end-of-stream item
// waits on a full result queue; only then can in_full rise. The summary
// enters a two-entry result queue when its end-of-stream item leaves the
// item queue, once any items ahead of it have drained, and is held there
// until popped; the scanner then starts afresh on the next stream.
module adts_frame_scanner_unit #(
  parameter int WINDOW_BYTES     = adts_fs_pkg::WINDOW_BYTES_DEF,
  parameter int ITEM_QUEUE_DEPTH = adts_fs_pkg::ITEM_Q_DEPTH_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_push,
  output logic                                    in_full,
  input  logic [7:0]                              in_data_byte,
  input  logic                                    in_byte_valid,
  input  logic                                    in_end_of_stream,
  output logic                                    out_empty,
  input  logic                                    out_pop,
  output logic [adts_fs_pkg::FRAME_CNT_W-1:0]     out_frame_count,
  output logic [adts_fs_pkg::TOTAL_W-1:0]         out_total_frame_bytes,
  output logic [adts_fs_pkg::RATE_IDX_W-1:0]      out_rate_index,
  output logic [adts_fs_pkg::RATE_HZ_W-1:0]       out_sample_rate,
  output logic                                    out_sync_found,
  output logic [adts_fs_pkg::CAUSE_W-1:0]         out_stop_cause
);

  import adts_fs_pkg::*;

  `include "adts_frame_scanner_unit_defines.svh"

  logic    mq_push;
  logic    mq_full;
  logic    mq_empty;
  logic    mq_pop;
  item_t   mq_wr_item;
  item_t   mq_rd_item;
  logic    rq_push;
  logic    rq_full;
  result_t rq_wr_res;
  result_t rq_rd_res;

  adts_fs_front u_front (
    .in_push          (in_push),
    .in_data_byte     (in_data_byte),
    .in_byte_valid    (in_byte_valid),
    .in_end_of_stream (in_end_of_stream),
    .in_full          (in_full),
    .q_full           (mq_full),
    .q_push           (mq_push),
    .q_item           (mq_wr_item)
  );

  adts_fs_queue #(
    .WIDTH ($bits(item_t)),
    .DEPTH (ITEM_QUEUE_DEPTH)
  ) u_item_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (mq_push),
    .wr_data (mq_wr_item),
    .pop     (mq_pop),
    .rd_data (mq_rd_item),
    .full    (mq_full),
    .empty   (mq_empty)
  );

  adts_fs_back #(
    .WINDOW_BYTES (WINDOW_BYTES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_empty (mq_empty),
    .item       (mq_rd_item),
    .item_pop   (mq_pop),
    .res_full   (rq_full),
    .res_push   (rq_push),
    .res        (rq_wr_res)
  );

  adts_fs_queue #(
    .WIDTH ($bits(result_t)),
    .DEPTH (RESULT_Q_DEPTH)
  ) u_result_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (rq_push),
    .wr_data (rq_wr_res),
    .pop     (out_pop),
    .rd_data (rq_rd_res),
    .full    (rq_full),
    .empty   (out_empty)
  );

  assign out_frame_count       = rq_rd_res.frame_count;
  assign out_total_frame_bytes = rq_rd_res.total_frame_bytes;
  assign out_rate_index        = rq_rd_res.rate_index;
  assign out_sample_rate       = rq_rd_res.sample_rate;
  assign out_sync_found        = rq_rd_res.sync_found;
  assign out_stop_cause        = rq_rd_res.stop_cause;

  `ADTS_ASSERT_NOW(a_rq_no_overflow, rq_push, !rq_full, "summary pushed into full result queue")
  `ADTS_ASSERT_NOW(a_mq_pop_valid, mq_pop, !mq_empty, "scan engine popped empty item queue")
  `ADTS_ASSERT_NEXT(a_rq_frees, out_pop && !out_empty && !rq_push, !rq_full, "result queue stuck full")
  `ADTS_ASSERT_NEXT(a_item_lands, in_push && !in_full && (in_byte_valid || in_end_of_stream), !mq_empty, "accepted transaction lost")

endmodule
